[rtl/barometric_sensor_compensation_top_defines.svh]
// ---------------------------------------------------------------------------
// barometric sensor compensation assertion macros
// concurrent checks clocked on i_clk, masked while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef BAROMETRIC_SENSOR_COMPENSATION_TOP_DEFINES_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_TOP_DEFINES_SVH

// condition holds in the same cycle
`define BSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bsc_pkg.sv]
// ---------------------------------------------------------------------------
// bsc_pkg
// shared constants, codes and rounding helper for the compensation block
// ---------------------------------------------------------------------------
package bsc_pkg;

    localparam int TEMP_FRAC_BITS  = 16;
    localparam int PRESS_FRAC_BITS = 6;

    // offset removed from p1 and p2
    localparam int P_OFFSET = 16384;

    // pipeline depth before the output register
    localparam int N_STAGES = 21;

    // internal fixed point widths
    localparam int D_W    = 26;
    localparam int U2_W   = 49;
    localparam int UP_W   = 34;
    localparam int DT2_W  = 44;
    localparam int DSQ_W  = 52;
    localparam int DSQ3_W = 60;
    localparam int NT_W   = 62;
    localparam int TQ_W   = 48;
    localparam int TQ2_W  = 58;
    localparam int TQ3_W  = 58;
    localparam int DD_W   = 54;
    localparam int TERM_W = 60;
    localparam int C_W    = 60;
    localparam int SUM_W  = 62;

    typedef enum logic [1:0] {
        CFG_TEMP = 2'd0,
        CFG_PA   = 2'd1,
        CFG_PB   = 2'd2,
        CFG_PC   = 2'd3
    } t_cfg_idx;

    // round(x / 2^k), half away from zero
    function automatic logic signed [127:0] round_hafz(input logic signed [127:0] x,
                                                      input int unsigned k);
        logic signed [127:0] half;
        logic signed [127:0] biased;
        half   = 128'sd1 <<< (k - 1);
        biased = x + half - $signed({127'd0, x[127]});
        return biased >>> k;
    endfunction

endpackage

[rtl/bsc_if.sv]
// ---------------------------------------------------------------------------
// bsc interfaces
// sample, result and calibration write channels with valid/ready
// ---------------------------------------------------------------------------
interface bsc_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] temp_code;
    logic [23:0] press_code;
    modport source(output valid, output temp_code, output press_code, input ready);
    modport sink(input valid, input temp_code, input press_code, output ready);
endinterface

interface bsc_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] temperature_c;
    logic [22:0]        pressure_pa;
    logic               saturated;
    modport source(output valid, output temperature_c, output pressure_pa,
                   output saturated, input ready);
    modport sink(input valid, input temperature_c, input pressure_pa,
                 input saturated, output ready);
endinterface

interface bsc_cfg_if import bsc_pkg::*;;
    logic        valid;
    logic        ready;
    t_cfg_idx    index;
    logic [47:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

[rtl/bsc_mul.sv]
// ---------------------------------------------------------------------------
// bsc_mul
// two-stage signed 64x64 multiplier built from four registered partials
// ---------------------------------------------------------------------------
module bsc_mul (
    input  logic                i_clk,
    input  logic [1:0]          i_en,
    input  logic signed [63:0]  i_a,
    input  logic signed [63:0]  i_b,
    output logic signed [127:0] o_p
);

    logic signed [31:0]  w_ah;
    logic signed [31:0]  w_bh;
    logic signed [32:0]  w_al;
    logic signed [32:0]  w_bl;
    logic signed [63:0]  r_hh;
    logic signed [64:0]  r_hl;
    logic signed [64:0]  r_lh;
    logic signed [65:0]  r_ll;
    logic signed [127:0] r_p;

    // high halves signed, low halves as positive 33-bit values
    assign w_ah = i_a[63:32];
    assign w_bh = i_b[63:32];
    assign w_al = $signed({1'b0, i_a[31:0]});
    assign w_bl = $signed({1'b0, i_b[31:0]});

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_hh <= w_ah * w_bh;
            r_hl <= w_ah * w_bl;
            r_lh <= w_al * w_bh;
            r_ll <= w_al * w_bl;
        end
        if (i_en[1]) begin
            r_p <= (128'(r_hh) <<< 64) + ((128'(r_hl) + 128'(r_lh)) <<< 32) + 128'(r_ll);
        end
    end

    assign o_p = r_p;

endmodule

[rtl/barometric_sensor_compensation_top.sv]
// each sample passes stages 1 to N_STAGES, then the output register, before result valid
// throughput: one sample pair per cycle while the pipe has room; a receiver that holds off fills it
// each stage moves on when it is empty or the stage after it moves on
// reset clears all valid bits and the calibration words; data registers are not reset
// ---------------------------------------------------------------------------
// barometric_sensor_compensation_top
// polynomial temperature and pressure compensation of raw sensor samples,
// fixed point throughout, saturating outputs with a flag
// ---------------------------------------------------------------------------
module barometric_sensor_compensation_top import bsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsc_in_if.sink     i_sample,
    bsc_cfg_if.sink    i_cfg,
    bsc_out_if.source  o_result
);

`include "barometric_sensor_compensation_top_defines.svh"

    // everything one sample carries down the pipe
    typedef struct packed {
        logic [23:0]               ut;
        logic [23:0]               u;
        logic signed [D_W-1:0]     d;
        logic signed [U2_W-1:0]    u2;
        logic signed [UP_W-1:0]    up11;
        logic signed [DT2_W-1:0]   dt2;
        logic signed [DSQ_W-1:0]   dsq;
        logic signed [DSQ3_W-1:0]  dsq3;
        logic signed [NT_W-1:0]    nt;
        logic signed [NT_W-1:0]    tt;
        logic signed [TQ_W-1:0]    tq;
        logic signed [TQ2_W-1:0]   tq2;
        logic signed [TQ3_W-1:0]   tq3;
        logic signed [DD_W-1:0]    dd;
        logic signed [TERM_W-1:0]  t6;
        logic signed [TERM_W-1:0]  t7;
        logic signed [TERM_W-1:0]  t8;
        logic signed [C_W-1:0]     ca;
        logic signed [C_W-1:0]     cb;
        logic signed [C_W-1:0]     cd;
        logic signed [C_W-1:0]     cab;
        logic signed [C_W-1:0]     c;
        logic signed [SUM_W-1:0]   sa;
        logic signed [SUM_W-1:0]   sb;
        logic signed [SUM_W-1:0]   ruc;
        logic signed [SUM_W-1:0]   rud;
        logic signed [SUM_W-1:0]   rup;
        logic signed [SUM_W-1:0]   sum;
        logic signed [SUM_W-1:0]   pr;
    } t_carry;

    typedef struct packed {
        logic signed [23:0] temperature_c;
        logic [22:0]        pressure_pa;
        logic               saturated;
    } t_result;

    // calibration words, raw as written
    logic [39:0] r_cal_t;
    logic [47:0] r_cal_a;
    logic [47:0] r_cal_b;
    logic [31:0] r_cal_c;

    // decoded coefficients
    logic [15:0]        w_t1;
    logic [15:0]        w_t2;
    logic signed [7:0]  w_t3;
    logic signed [17:0] w_p1;
    logic signed [17:0] w_p2;
    logic signed [7:0]  w_p3;
    logic signed [7:0]  w_p4;
    logic [15:0]        w_p5;
    logic [15:0]        w_p6;
    logic signed [7:0]  w_p7;
    logic signed [7:0]  w_p8;
    logic signed [15:0] w_p9;
    logic signed [7:0]  w_p10;
    logic signed [7:0]  w_p11;

    // pipeline
    t_carry              r_c [1:N_STAGES];
    t_carry              n_c [1:N_STAGES];
    logic [N_STAGES:1]   r_v;
    logic [N_STAGES+1:1] w_adv;
    t_result             r_out;
    t_result             n_out;
    logic                r_ov;

    // multiplier products
    logic signed [127:0] w_p_tt;
    logic signed [127:0] w_p_p6;
    logic signed [127:0] w_p_p2;
    logic signed [127:0] w_p_p10;
    logic signed [127:0] w_p_t3;
    logic signed [127:0] w_p_p7;
    logic signed [127:0] w_p_p3;
    logic signed [127:0] w_p_p8;
    logic signed [127:0] w_p_p4;
    logic signed [127:0] w_p_uc;
    logic signed [127:0] w_p_ud;
    logic signed [127:0] w_p_up;

    // -----------------------------------------------------------------------
    // calibration port, always ready
    // -----------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t <= '0;
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_TEMP: r_cal_t <= i_cfg.data[39:0];
                CFG_PA:   r_cal_a <= i_cfg.data;
                CFG_PB:   r_cal_b <= i_cfg.data;
                CFG_PC:   r_cal_c <= i_cfg.data[31:0];
            endcase
        end
    end

    // byte 0 is the lowest byte of each word
    assign w_t1  = r_cal_t[15:0];
    assign w_t2  = r_cal_t[31:16];
    assign w_t3  = r_cal_t[39:32];
    assign w_p1  = 18'($signed(r_cal_a[15:0])) - 18'(P_OFFSET);
    assign w_p2  = 18'($signed(r_cal_a[31:16])) - 18'(P_OFFSET);
    assign w_p3  = r_cal_a[39:32];
    assign w_p4  = r_cal_a[47:40];
    assign w_p5  = r_cal_b[15:0];
    assign w_p6  = r_cal_b[31:16];
    assign w_p7  = r_cal_b[39:32];
    assign w_p8  = r_cal_b[47:40];
    assign w_p9  = r_cal_c[15:0];
    assign w_p10 = r_cal_c[23:16];
    assign w_p11 = r_cal_c[31:24];

    // -----------------------------------------------------------------------
    // flow control: a stage loads when empty or when the next one loads
    // -----------------------------------------------------------------------
    always_comb begin
        w_adv[N_STAGES+1] = !r_ov || o_result.ready;
        for (int i = N_STAGES; i >= 1; i--) begin
            w_adv[i] = !r_v[i] || w_adv[i+1];
        end
    end

    assign i_sample.ready = w_adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            if (w_adv[1]) begin
                r_v[1] <= i_sample.valid;
            end
            for (int i = 2; i <= N_STAGES; i++) begin
                if (w_adv[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
            if (w_adv[N_STAGES+1]) begin
                r_ov <= r_v[N_STAGES];
            end
        end
    end

    // -----------------------------------------------------------------------
    // shared multiplier design, one instance per product, two stages each
    // -----------------------------------------------------------------------
    // stages 7-8: products with the internal temperature
    bsc_mul u_mul_tt (.i_clk(i_clk), .i_en(w_adv[8:7]),
                      .i_a(64'(r_c[6].tq)), .i_b(64'(r_c[6].tq)), .o_p(w_p_tt));
    bsc_mul u_mul_p6 (.i_clk(i_clk), .i_en(w_adv[8:7]),
                      .i_a(64'($signed({1'b0, w_p6}))), .i_b(64'(r_c[6].tq)), .o_p(w_p_p6));
    bsc_mul u_mul_p2 (.i_clk(i_clk), .i_en(w_adv[8:7]),
                      .i_a(64'(w_p2)), .i_b(64'(r_c[6].tq)), .o_p(w_p_p2));
    bsc_mul u_mul_p10 (.i_clk(i_clk), .i_en(w_adv[8:7]),
                       .i_a(64'(w_p10)), .i_b(64'(r_c[6].tq)), .o_p(w_p_p10));

    // stages 10-11: products with the squared temperature
    bsc_mul u_mul_t3 (.i_clk(i_clk), .i_en(w_adv[11:10]),
                      .i_a(64'(r_c[9].tq2)), .i_b(64'(r_c[9].tq)), .o_p(w_p_t3));
    bsc_mul u_mul_p7 (.i_clk(i_clk), .i_en(w_adv[11:10]),
                      .i_a(64'(w_p7)), .i_b(64'(r_c[9].tq2)), .o_p(w_p_p7));
    bsc_mul u_mul_p3 (.i_clk(i_clk), .i_en(w_adv[11:10]),
                      .i_a(64'(w_p3)), .i_b(64'(r_c[9].tq2)), .o_p(w_p_p3));

    // stages 13-14: products with the cubed temperature
    bsc_mul u_mul_p8 (.i_clk(i_clk), .i_en(w_adv[14:13]),
                      .i_a(64'(w_p8)), .i_b(64'(r_c[12].tq3)), .o_p(w_p_p8));
    bsc_mul u_mul_p4 (.i_clk(i_clk), .i_en(w_adv[14:13]),
                      .i_a(64'(w_p4)), .i_b(64'(r_c[12].tq3)), .o_p(w_p_p4));

    // stages 17-18: products with the raw pressure
    bsc_mul u_mul_uc (.i_clk(i_clk), .i_en(w_adv[18:17]),
                      .i_a(64'($signed({1'b0, r_c[16].u}))), .i_b(64'(r_c[16].c)),
                      .o_p(w_p_uc));
    bsc_mul u_mul_ud (.i_clk(i_clk), .i_en(w_adv[18:17]),
                      .i_a(64'(r_c[16].u2)), .i_b(64'(r_c[16].dd)), .o_p(w_p_ud));
    bsc_mul u_mul_up (.i_clk(i_clk), .i_en(w_adv[18:17]),
                      .i_a(64'(r_c[16].u2)), .i_b(64'(r_c[16].up11)), .o_p(w_p_up));

    // -----------------------------------------------------------------------
    // datapath stages
    // -----------------------------------------------------------------------
    always_comb begin
        logic signed [127:0] v_a;
        logic signed [127:0] v_b;
        logic signed [127:0] v_e;
        logic [47:0]         v_usq;

        for (int i = 2; i <= N_STAGES; i++) begin
            n_c[i] = r_c[i-1];
        end

        // 1: sample capture
        n_c[1]    = r_c[1];
        n_c[1].ut = i_sample.temp_code;
        n_c[1].u  = i_sample.press_code;

        // 2: temperature offset, pressure square and p11 product
        v_usq       = 48'(r_c[1].u) * 48'(r_c[1].u);
        n_c[2].d    = $signed({2'b00, r_c[1].ut}) - $signed({2'b00, w_t1, 8'd0});
        n_c[2].u2   = $signed({1'b0, v_usq});
        n_c[2].up11 = UP_W'($signed({1'b0, r_c[1].u}) * w_p11);

        // 3: linear and square temperature terms
        n_c[3].dt2 = DT2_W'(r_c[2].d * $signed({1'b0, w_t2}));
        n_c[3].dsq = DSQ_W'(r_c[2].d * r_c[2].d);

        // 4: scale square term by t3
        n_c[4].dsq3 = DSQ3_W'(r_c[3].dsq * w_t3);

        // 5: exact temperature, 48 fraction bits
        n_c[5].nt = (NT_W'(r_c[4].dt2) <<< 18) + NT_W'(r_c[4].dsq3);

        // 6: internal temperature and output temperature
        v_a       = round_hafz(128'(r_c[5].nt), 16);
        v_b       = round_hafz(128'(r_c[5].nt), 48 - TEMP_FRAC_BITS);
        n_c[6].tq = v_a[TQ_W-1:0];
        n_c[6].tt = v_b[NT_W-1:0];

        // 9: square, p6 and p2 terms, exact D
        v_a        = round_hafz(w_p_tt, 32);
        v_b        = round_hafz(w_p_p6, 14);
        v_e        = round_hafz(w_p_p2, 5);
        n_c[9].tq2 = v_a[TQ2_W-1:0];
        n_c[9].t6  = v_b[TERM_W-1:0];
        n_c[9].ca  = v_e[C_W-1:0];
        n_c[9].dd  = (DD_W'(w_p9) <<< 32) + w_p_p10[DD_W-1:0];

        // 12: cube, p7 and p3 terms
        v_a         = round_hafz(w_p_t3, 40);
        v_b         = round_hafz(w_p_p7, 16);
        v_e         = round_hafz(w_p_p3, 8);
        n_c[12].tq3 = v_a[TQ3_W-1:0];
        n_c[12].t7  = v_b[TERM_W-1:0];
        n_c[12].cb  = v_e[C_W-1:0];

        // 13: partial sums of C and of the temperature-only terms
        n_c[13].cab = (C_W'(w_p1) <<< 36) + r_c[12].ca + r_c[12].cb;
        n_c[13].sa  = (SUM_W'($signed({1'b0, w_p5})) <<< 27) + SUM_W'(r_c[12].t6)
                      + SUM_W'(r_c[12].t7);

        // 15: p8 and p4 terms
        v_a        = round_hafz(w_p_p8, 15);
        v_b        = round_hafz(w_p_p4, 5);
        n_c[15].t8 = v_a[TERM_W-1:0];
        n_c[15].cd = v_b[C_W-1:0];

        // 16: complete C and the temperature-only sum
        n_c[16].c  = r_c[15].cab + r_c[15].cd;
        n_c[16].sb = r_c[15].sa + SUM_W'(r_c[15].t8);

        // 19: pressure-dependent terms
        v_a         = round_hafz(w_p_uc, 32);
        v_b         = round_hafz(w_p_ud, 56);
        v_e         = round_hafz(w_p_up, 41);
        n_c[19].ruc = v_a[SUM_W-1:0];
        n_c[19].rud = v_b[SUM_W-1:0];
        n_c[19].rup = v_e[SUM_W-1:0];

        // 20: pressure, 24 fraction bits
        n_c[20].sum = r_c[19].sb + r_c[19].ruc + r_c[19].rud + r_c[19].rup;

        // 21: output pressure scale
        v_a        = round_hafz(128'(r_c[20].sum), 24 - PRESS_FRAC_BITS);
        n_c[21].pr = v_a[SUM_W-1:0];
    end

    // output register: saturation of both values
    always_comb begin
        n_out = '0;
        if (r_c[N_STAGES].tt > NT_W'(24'sh7fffff)) begin
            n_out.temperature_c = 24'sh7fffff;
            n_out.saturated     = 1'b1;
        end else if (r_c[N_STAGES].tt < -NT_W'(25'sh0800000)) begin
            n_out.temperature_c = 24'sh800000;
            n_out.saturated     = 1'b1;
        end else begin
            n_out.temperature_c = r_c[N_STAGES].tt[23:0];
        end
        if (r_c[N_STAGES].pr < 0) begin
            n_out.pressure_pa = '0;
            n_out.saturated   = 1'b1;
        end else if (r_c[N_STAGES].pr > SUM_W'(24'sh7fffff)) begin
            n_out.pressure_pa = 23'h7fffff;
            n_out.saturated   = 1'b1;
        end else begin
            n_out.pressure_pa = r_c[N_STAGES].pr[22:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 1; i <= N_STAGES; i++) begin
            if (w_adv[i]) begin
                r_c[i] <= n_c[i];
            end
        end
        if (w_adv[N_STAGES+1]) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid         = r_ov;
    assign o_result.temperature_c = r_out.temperature_c;
    assign o_result.pressure_pa   = r_out.pressure_pa;
    assign o_result.saturated     = r_out.saturated;

    // -----------------------------------------------------------------------
    // checks
    // -----------------------------------------------------------------------
    `BSC_ASSERT_NEXT(a_sample_enters, i_sample.valid && i_sample.ready, r_v[1], "accepted sample missing from first stage")
    `BSC_ASSERT_NEXT(a_last_stage_held, r_v[N_STAGES] && !w_adv[N_STAGES+1], r_v[N_STAGES] && r_ov, "stalled item dropped at last stage")
    `BSC_ASSERT_NOW(a_ready_only_when_full, !i_sample.ready, (&r_v) && r_ov, "sample refused while pipeline has room")

endmodule

[verif/tb_barometric_sensor_compensation_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_barometric_sensor_compensation_top
// drives raw temperature and pressure samples under a range of calibration
// settings, predicts each compensated reading and checks every result
// ---------------------------------------------------------------------------
module tb_barometric_sensor_compensation_top import bsc_pkg::*;;

    localparam int              CLK_HALF   = 6;
    localparam int              DRAIN_WAIT = 40;      // settling wait once every reading has come back
    localparam int              STALL_MAX  = 20000;   // cycles with no transfer at all
    localparam logic [127:0]    MAG_MAX    = 128'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [23:0] temperature_c;
        logic [22:0]        pressure_pa;
        logic               saturated;
    } t_reading;

    logic i_clk;
    logic i_rst_n;

    bsc_in_if  smp();
    bsc_cfg_if cfg();
    bsc_out_if res();

    barometric_sensor_compensation_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp.sink),
        .i_cfg    (cfg.sink),
        .o_result (res.source)
    );

    // calibration words as the block should hold them
    logic [39:0] cal_temp;
    logic [47:0] cal_pa;
    logic [47:0] cal_pb;
    logic [31:0] cal_pc;

    t_reading    expected_readings[$];
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          quiet_cycles;
    bit          failed;

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // ------------------------------------------------------------------
    // fixed point helpers, round half away from zero with magnitude clamp
    // ------------------------------------------------------------------
    function automatic longint signed_mag(input logic [127:0] m, input bit neg);
        logic [127:0] c;
        c = (m > MAG_MAX) ? MAG_MAX : m;
        return neg ? -longint'(c[63:0]) : longint'(c[63:0]);
    endfunction

    function automatic logic [127:0] abs128(input longint x);
        return (x < 0) ? 128'(-x) : 128'(x);
    endfunction

    function automatic longint round_shift(input longint x, input int k);
        logic [127:0] m;
        m = (abs128(x) + (128'd1 << (k - 1))) >> k;
        return signed_mag(m, x < 0);
    endfunction

    function automatic longint round_product(input longint a, input longint b, input int k);
        logic [127:0] m;
        m = (abs128(a) * abs128(b) + (128'd1 << (k - 1))) >> k;
        return signed_mag(m, (a < 0) != (b < 0));
    endfunction

    // compensated reading for one sample pair under the current calibration
    function automatic t_reading compensate(input logic [23:0] raw_t, input logic [23:0] raw_p);
        longint   t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        longint   ut, up, d, nt, tq, tq2, tq3, c, dd, up2, sum, tout, pout;
        t_reading r;
        t1  = longint'(cal_temp[15:0]);
        t2  = longint'(cal_temp[31:16]);
        t3  = longint'($signed(cal_temp[39:32]));
        p1  = longint'($signed(cal_pa[15:0])) - P_OFFSET;
        p2  = longint'($signed(cal_pa[31:16])) - P_OFFSET;
        p3  = longint'($signed(cal_pa[39:32]));
        p4  = longint'($signed(cal_pa[47:40]));
        p5  = longint'(cal_pb[15:0]);
        p6  = longint'(cal_pb[31:16]);
        p7  = longint'($signed(cal_pb[39:32]));
        p8  = longint'($signed(cal_pb[47:40]));
        p9  = longint'($signed(cal_pc[15:0]));
        p10 = longint'($signed(cal_pc[23:16]));
        p11 = longint'($signed(cal_pc[31:24]));
        ut  = longint'(raw_t);
        up  = longint'(raw_p);
        r.saturated = 1'b0;

        d  = ut - t1 * 256;
        nt = d * t2 * (64'sd1 <<< 18) + d * d * t3;

        tout = round_shift(nt, 48 - TEMP_FRAC_BITS);
        if (tout > 8388607) begin
            tout = 8388607;
            r.saturated = 1'b1;
        end
        if (tout < -8388608) begin
            tout = -8388608;
            r.saturated = 1'b1;
        end

        tq  = round_shift(nt, 16);
        tq2 = round_product(tq, tq, 32);
        tq3 = round_product(tq2, tq, 40);

        sum = p5 * (64'sd1 <<< 27);
        sum += round_product(p6, tq, 14);
        sum += round_product(p7, tq2, 16);
        sum += round_product(p8, tq3, 15);
        c = p1 * (64'sd1 <<< 36) + round_product(p2, tq, 5) + round_product(p3, tq2, 8)
            + round_product(p4, tq3, 5);
        sum += round_product(up, c, 32);
        up2 = up * up;
        dd  = p9 * (64'sd1 <<< 32) + p10 * tq;
        sum += round_product(up2, dd, 56);
        sum += round_product(up2, up * p11, 41);

        pout = round_shift(sum, 24 - PRESS_FRAC_BITS);
        if (pout < 0) begin
            pout = 0;
            r.saturated = 1'b1;
        end
        if (pout > 8388607) begin
            pout = 8388607;
            r.saturated = 1'b1;
        end
        r.temperature_c = tout[23:0];
        r.pressure_pa   = pout[22:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // monitors: calibration and sample transfers, result checks, watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_TEMP: cal_temp <= cfg.data[39:0];
                    CFG_PA:   cal_pa   <= cfg.data;
                    CFG_PB:   cal_pb   <= cfg.data;
                    CFG_PC:   cal_pc   <= cfg.data[31:0];
                    default: ;
                endcase
            end
            // calibration only changes while idle, so the current words apply
            if (smp.valid && smp.ready)
                expected_readings.push_back(compensate(smp.temp_code, smp.press_code));
            if (res.valid && res.ready) begin
                if (expected_readings.size() == 0) begin
                    $error("unexpected result transfer: temperature_c %0d pressure_pa %0d",
                           res.temperature_c, res.pressure_pa);
                    failed = 1'b1;
                end else begin
                    t_reading e;
                    e = expected_readings.pop_front();
                    if (res.temperature_c !== e.temperature_c) begin
                        $error("temperature_c expected %0d actual %0d",
                               e.temperature_c, res.temperature_c);
                        failed = 1'b1;
                    end
                    if (res.pressure_pa !== e.pressure_pa) begin
                        $error("pressure_pa expected %0d actual %0d",
                               e.pressure_pa, res.pressure_pa);
                        failed = 1'b1;
                    end
                    if (res.saturated !== e.saturated) begin
                        $error("saturated expected %0b actual %0b", e.saturated, res.saturated);
                        failed = 1'b1;
                    end
                end
            end
            // watchdog on any channel moving
            if ((smp.valid && smp.ready) || (res.valid && res.ready)
                    || (cfg.valid && cfg.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX) begin
                $display("barometric_sensor_compensation_top: mismatch");
                $finish;
            end
        end
    end

    // receiver back-pressure, changed on the falling edge
    always @(negedge i_clk)
        res.ready <= ($urandom_range(99) >= receiver_stall_pct);

    // ------------------------------------------------------------------
    // shared driving tasks
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [23:0] raw_t, input logic [23:0] raw_p);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            smp.valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(negedge i_clk);
        end
        smp.valid      <= 1'b1;
        smp.temp_code  <= raw_t;
        smp.press_code <= raw_p;
        @(posedge i_clk);
        while (!smp.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drop valid and let every outstanding reading come back
    task automatic drain();
        smp.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_readings.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_cal(input t_cfg_idx idx, input logic [47:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge i_clk);
        while (!cfg.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_cal_words(input logic [39:0] t, input logic [47:0] a,
                                 input logic [47:0] b, input logic [31:0] c);
        drain();
        write_cal(CFG_TEMP, {8'd0, t});
        write_cal(CFG_PA, a);
        write_cal(CFG_PB, b);
        write_cal(CFG_PC, {16'd0, c});
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom()), $urandom()};
    endfunction

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------

    // reset calibration is all zero; extremes of the raw fields
    task automatic test_reset_calibration();
        send_sample(24'h000000, 24'h000000);
        send_sample(24'hFFFFFF, 24'hFFFFFF);
        send_sample(24'h800000, 24'h7FFFFF);
    endtask

    // all-ones calibration drives both outputs hard into saturation
    task automatic test_saturation_extremes();
        set_cal_words('1, '1, '1, '1);
        send_sample(24'h000000, 24'h000000);
        send_sample(24'hFFFFFF, 24'hFFFFFF);
        send_sample(24'hFFFF00, 24'h000001);
        send_sample(24'h5A5A5A, 24'hA5A5A5);
        // largest positive coefficients, negative ones at their minimum
        set_cal_words({8'h7F, 16'hFFFF, 16'h0000},
                      {8'h80, 8'h7F, 16'h8000, 16'h7FFF},
                      {8'h7F, 8'h80, 16'hFFFF, 16'hFFFF},
                      {8'h80, 8'h7F, 16'h7FFF});
        send_sample(24'hFFFFFF, 24'h000000);
        send_sample(24'h000000, 24'hFFFFFF);
        send_sample(24'h000100, 24'h800000);
        send_sample(24'hFFFFFF, 24'hFFFFFF);
    endtask

    // a plausible sensor calibration: near-zero temperatures, in-range pressure
    task automatic test_typical_calibration();
        set_cal_words({8'hF6, 16'd18000, 16'd27500},
                      {8'h03, 8'h20, 16'd17000, 16'd16500},
                      {8'h0F, 8'hF8, 16'd5000, 16'd3000},
                      {8'h00, 8'h01, 16'd100});
        send_sample(24'(27500 * 256), 24'd0);
        send_sample(24'(27500 * 256 + 1), 24'd3000000);
        send_sample(24'(27500 * 256 - 1), 24'd6000000);
        send_sample(24'(27500 * 256 + 16384), 24'd8000000);
        send_sample(24'(27500 * 256 - 16384), 24'hFFFFFF);
        send_sample(24'h000000, 24'd5000000);
    endtask

    // random calibration sets and samples, with the idling pattern given
    task automatic test_random_phase(input int sender_pct, input int receiver_pct,
                                     input int n_items);
        logic [39:0] t_word;
        logic [23:0] centre;
        logic [23:0] raw_t;
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % 64 == 0) begin
                t_word = {8'($urandom_range(255)), 16'($urandom_range(65535)),
                          16'($urandom_range(65535))};
                set_cal_words(t_word, rand48(), rand48(), $urandom());
            end
            // mostly samples near the calibrated zero point, the rest anywhere
            centre = {t_word[15:0], 8'd0};
            if ($urandom_range(3) != 0)
                raw_t = centre + 24'($signed(19'($urandom())));
            else
                raw_t = 24'($urandom());
            send_sample(raw_t, 24'($urandom()));
            // one hold-off until the block runs dry
            if (i == n_items / 2)
                drain();
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        smp.valid          = 1'b0;
        smp.temp_code      = '0;
        smp.press_code     = '0;
        cfg.valid          = 1'b0;
        cfg.index          = CFG_TEMP;
        cfg.data           = '0;
        res.ready          = 1'b0;
        cal_temp           = '0;
        cal_pa             = '0;
        cal_pb             = '0;
        cal_pc             = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        quiet_cycles       = 0;
        failed             = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_calibration();
        test_saturation_extremes();
        test_typical_calibration();
        test_random_phase(10, 82, 380);
        test_random_phase(82, 10, 380);
        test_random_phase(0, 0, 390);
        drain();

        if (!failed)
            $display("barometric_sensor_compensation_top: match");
        else
            $display("barometric_sensor_compensation_top: mismatch");
        $finish;
    end

endmodule
